// File: design/adab_pkg.sv
// ---------------------------------------------------------------------------
// adab_pkg
// Shared types and constants for the belief-variance optimizer update.
// ---------------------------------------------------------------------------
package adab_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 24;
   localparam int BetaFrac  = 24;
   localparam int VarWidth  = DataWidth - 1;
   localparam int BetaWidth = 24;
   localparam int CsrIdxW   = 3;

   localparam logic [BetaFrac:0] BetaOne = 25'h1000000;
   localparam logic [VarWidth-1:0] PosMax = {VarWidth{1'b1}};

   localparam logic [CsrIdxW-1:0] CsrLearnRate = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrBetaMean  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrBetaVar   = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrEpsValue  = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrStepCount = 3'd4;

   typedef struct packed {
      logic signed [DataWidth-1:0] gradient;
      logic signed [DataWidth-1:0] prev_mean;
      logic [VarWidth-1:0]         prev_var;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] update_value;
      logic signed [DataWidth-1:0] new_mean;
      logic [VarWidth-1:0]         new_var;
   } rsp_type;

   typedef struct packed {
      logic [CsrIdxW-1:0] index;
      logic [31:0]        data;
   } csr_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [BetaWidth-1:0] beta_mean;
      logic [BetaWidth-1:0] beta_var;
      logic [VarWidth-1:0]  eps;
      logic [VarWidth-1:0]  step_factor;
   } dp_cfg_type;

   typedef enum logic [2:0] {
      FAC_IDLE, FAC_POW, FAC_SQRT, FAC_MUL, FAC_DIV, FAC_DONE
   } fac_state_type;

   // round half up a product by BetaFrac bits
   function automatic logic [63:0] urnd(input logic [63:0] p);
      urnd = (p >> BetaFrac) + {63'd0, p[BetaFrac-1]};
   endfunction

endpackage

// File: design/adab_if.sv
// ---------------------------------------------------------------------------
// adab_stream_if / adab_csr_if
// Valid/ready channels for items, results and register writes.
// ---------------------------------------------------------------------------
interface adab_stream_if #(type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface adab_csr_if;
   logic                           valid;
   logic                           ready;
   logic [adab_pkg::CsrIdxW-1:0]   index;
   logic [31:0]                    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/adabelief_update_unit.sv
// ---------------------------------------------------------------------------
// adabelief_update_unit
// Belief-variance optimizer update for one tensor element per transaction.
// ---------------------------------------------------------------------------
// channel  dir  payload
// req      in   gradient, prev_mean, prev_var
// rsp      out  update_value, new_mean, new_var
// csr      in   index, data (learn_rate, beta_mean, beta_var, eps, step_count)
//
// One element per cycle once the step factor is ready and rsp is not stalled; the
// pipeline holds the root chain (28 steps) and the restoring divider (21 stages of 3 bits).
// After reset the first element waits while the step factor unit runs its
// power, root and divide loops; the factor then holds until reset.
// A stalled rsp freezes the whole pipeline; nothing is dropped.
module adabelief_update_unit (
   input  logic clock,
   input  logic reset,
   adab_stream_if.sink   req,
   adab_stream_if.source rsp,
   adab_csr_if.sink      csr
);
   import adab_pkg::*;

   logic [VarWidth-1:0]  learn_rate_ff, eps_value_ff, step_count_ff;
   logic [BetaWidth-1:0] beta_mean_ff, beta_var_ff;
   logic fac_done, fac_start_ff, advance, pipe_valid;
   logic [VarWidth-1:0] factor;
   dp_cfg_type cfg;
   req_type    req_data;
   rsp_type    pipe_data;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= VarWidth'(16777);
         beta_mean_ff  <= BetaWidth'(15099494);
         beta_var_ff   <= BetaWidth'(16760439);
         eps_value_ff  <= '0;
         step_count_ff <= '0;
         fac_start_ff  <= 1'b0;
      end else begin
         // first item launches the factor computation
         if (req.valid) fac_start_ff <= 1'b1;
         if (csr.valid) begin
            case (csr.index)
               CsrLearnRate: learn_rate_ff <= csr.data[VarWidth-1:0];
               CsrBetaMean:  beta_mean_ff  <= csr.data[BetaWidth-1:0];
               CsrBetaVar:   beta_var_ff   <= csr.data[BetaWidth-1:0];
               CsrEpsValue:  eps_value_ff  <= csr.data[VarWidth-1:0];
               CsrStepCount: step_count_ff <= csr.data[VarWidth-1:0];
               default: ;
            endcase
         end
      end
   end

   adab_factor u_factor (
      .clock, .reset, .start(fac_start_ff),
      .learn_rate(learn_rate_ff), .beta_mean(beta_mean_ff),
      .beta_var(beta_var_ff), .eps(cfg.eps), .step_count(step_count_ff),
      .done(fac_done), .factor(factor)
   );

   always_comb begin
      cfg.beta_mean   = beta_mean_ff;
      cfg.beta_var    = beta_var_ff;
      cfg.eps         = (eps_value_ff == '0) ? VarWidth'(1) : eps_value_ff;
      cfg.step_factor = factor;
      req_data        = req.payload;
   end

   // advance whenever the output slot is free or being drained
   assign advance   = !pipe_valid || rsp.ready;
   assign req.ready = fac_done && advance;

   adab_pipe u_pipe (
      .clock, .reset, .advance,
      .in_valid(req.valid && req.ready), .in_data(req_data), .cfg,
      .out_valid(pipe_valid), .out_data(pipe_data)
   );

   assign rsp.valid   = pipe_valid;
   assign rsp.payload = pipe_data;
endmodule

// File: design/adab_factor.sv
// ---------------------------------------------------------------------------
// adab_factor
// Sequential unit that computes the bias-corrected step factor.
// ---------------------------------------------------------------------------
module adab_factor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [adab_pkg::VarWidth-1:0] learn_rate,
   input  logic [adab_pkg::BetaWidth-1:0] beta_mean,
   input  logic [adab_pkg::BetaWidth-1:0] beta_var,
   input  logic [adab_pkg::VarWidth-1:0] eps,
   input  logic [adab_pkg::VarWidth-1:0] step_count,
   output logic                          done,
   output logic [adab_pkg::VarWidth-1:0] factor
);
   import adab_pkg::*;

   fac_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] exp_ff, exp_in;
   logic [24:0] b1_ff, b1_in, b2_ff, b2_in, a1_ff, a1_in, a2_ff, a2_in;
   logic [49:0] rad_ff, rad_in;
   logic [47:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [55:0] num_ff, num_in;
   logic [24:0] dvs_ff, dvs_in;
   logic [55:0] quo_ff, quo_in;
   logic [80:0] drem_ff, drem_in;
   logic [VarWidth-1:0] factor_ff, factor_in;
   logic [26:0] trial;
   logic [49:0] sh_rem;
   logic [80:0] dr_sh;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FAC_IDLE: if (start) state_in = FAC_POW;
         FAC_POW:  if (cnt_ff == 6'd31) state_in = FAC_SQRT;
         FAC_SQRT: if (cnt_ff == 6'd24) state_in = FAC_MUL;
         FAC_MUL:  state_in = FAC_DIV;
         FAC_DIV:  if (cnt_ff == 6'd55) state_in = FAC_DONE;
         FAC_DONE: state_in = FAC_DONE;
         default:  state_in = FAC_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      exp_in = exp_ff;
      b1_in = b1_ff; b2_in = b2_ff; a1_in = a1_ff; a2_in = a2_ff;
      rad_in = rad_ff; rem_in = rem_ff; root_in = root_ff;
      num_in = num_ff; dvs_in = dvs_ff; quo_in = quo_ff; drem_in = drem_ff;
      factor_in = factor_ff;
      sh_rem = '0; trial = '0; dr_sh = '0;
      case (state_ff)
         FAC_IDLE: begin
            cnt_in = '0;
            exp_in = {1'b0, step_count} + 32'd1;
            b1_in = {1'b0, beta_mean};
            b2_in = {1'b0, beta_var};
            a1_in = BetaOne;
            a2_in = BetaOne;
         end
         FAC_POW: begin
            // square-and-multiply, one exponent bit per cycle
            if (exp_ff[0]) begin
               a1_in = 25'(urnd(64'(a1_ff) * 64'(b1_ff)));
               a2_in = 25'(urnd(64'(a2_ff) * 64'(b2_ff)));
            end
            b1_in = 25'(urnd(64'(b1_ff) * 64'(b1_ff)));
            b2_in = 25'(urnd(64'(b2_ff) * 64'(b2_ff)));
            exp_in = exp_ff >> 1;
            cnt_in = (cnt_ff == 6'd31) ? 6'd0 : cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               rad_in = {1'b0, BetaOne - a2_in, 24'd0};
               rem_in = '0;
               root_in = '0;
            end
         end
         FAC_SQRT: begin
            // restoring root, two radicand bits per cycle
            sh_rem = {rem_ff, rad_ff[49:48]};
            trial = {root_ff, 2'b01};
            rad_in = rad_ff << 2;
            if (sh_rem >= 50'(trial)) begin
               rem_in = 48'(sh_rem - 50'(trial));
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in = 48'(sh_rem);
               root_in = {root_ff[23:0], 1'b0};
            end
            cnt_in = (cnt_ff == 6'd24) ? 6'd0 : cnt_ff + 6'd1;
         end
         FAC_MUL: begin
            num_in = 56'(learn_rate) * 56'(root_ff);
            dvs_in = BetaOne - a1_ff;
            quo_in = '0;
            drem_in = '0;
         end
         FAC_DIV: begin
            // restoring division, one quotient bit per cycle
            dr_sh = {drem_ff[79:0], num_ff[55]};
            num_in = num_ff << 1;
            if (dr_sh >= 81'(dvs_ff)) begin
               drem_in = dr_sh - 81'(dvs_ff);
               quo_in = {quo_ff[54:0], 1'b1};
            end else begin
               drem_in = dr_sh;
               quo_in = {quo_ff[54:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               if (quo_in > 56'(PosMax)) factor_in = PosMax;
               else if (quo_in == '0) factor_in = eps;
               else factor_in = VarWidth'(quo_in);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FAC_IDLE;
         cnt_ff    <= '0;
         factor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         factor_ff <= factor_in;
      end
      exp_ff <= exp_in;
      b1_ff <= b1_in; b2_ff <= b2_in; a1_ff <= a1_in; a2_ff <= a2_in;
      rad_ff <= rad_in; rem_ff <= rem_in; root_ff <= root_in;
      num_ff <= num_in; dvs_ff <= dvs_in; quo_ff <= quo_in; drem_ff <= drem_in;
   end

   assign done   = (state_ff == FAC_DONE);
   assign factor = factor_ff;
endmodule

// File: design/adab_sqrt_stage.sv
// ---------------------------------------------------------------------------
// adab_sqrt_stage
// One pipelined step of the integer square root: two radicand bits.
// ---------------------------------------------------------------------------
module adab_sqrt_stage (
   input  logic [adab_pkg::VarWidth+adab_pkg::FracBits:0] rad_i,
   input  logic [27:0]                                     rem_i,
   input  logic [27:0]                                     root_i,
   output logic [adab_pkg::VarWidth+adab_pkg::FracBits:0] rad_o,
   output logic [27:0]                                     rem_o,
   output logic [27:0]                                     root_o
);
   import adab_pkg::*;
   localparam int RW = VarWidth + FracBits + 1;
   logic [29:0] sh_rem, trial;

   always_comb begin
      sh_rem = {rem_i, rad_i[RW-1:RW-2]};
      trial  = {root_i, 2'b01};
      rad_o  = rad_i << 2;
      if (sh_rem >= trial) begin
         rem_o  = 28'(sh_rem - trial);
         root_o = {root_i[26:0], 1'b1};
      end else begin
         rem_o  = 28'(sh_rem);
         root_o = {root_i[26:0], 1'b0};
      end
   end
endmodule

// File: design/adab_pipe.sv
// ---------------------------------------------------------------------------
// adab_pipe
// Element pipeline: moment, variance, root and update division.
// ---------------------------------------------------------------------------
module adab_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  adab_pkg::req_type        in_data,
   input  adab_pkg::dp_cfg_type     cfg,
   output logic                     out_valid,
   output adab_pkg::rsp_type        out_data
);
   import adab_pkg::*;

   localparam int RW     = VarWidth + FracBits + 1; // 56-bit radicand
   localparam int SqN    = 28;                    // root steps
   localparam int MagW   = 63;                    // |m| * s
   localparam int DivN   = MagW;                  // quotient bits
   localparam int DivPer = 3;                     // quotient bits per stage
   localparam int DivS   = DivN / DivPer;
   localparam int DenW   = 32;

   // stage 1: moment products
   logic v1_ff;
   logic signed [57:0] pm_a_ff, pm_b_ff;
   logic signed [DataWidth-1:0] g1_ff;
   logic [VarWidth-1:0] u01_ff;
   // stage 2: moment
   logic v2_ff;
   logic signed [DataWidth-1:0] m2_ff, g2_ff;
   logic [VarWidth-1:0] u02_ff;
   // stage 3: square
   logic v3_ff;
   logic [65:0] sq3_ff;
   logic signed [DataWidth-1:0] m3_ff;
   logic [VarWidth-1:0] u03_ff;
   // stage 4: beta products
   logic v4_ff;
   logic [63:0] t1_ff, t2_ff;
   logic signed [DataWidth-1:0] m4_ff;
   // stage 5: variance
   logic v5_ff;
   logic [VarWidth-1:0] u5_ff;
   logic signed [DataWidth-1:0] m5_ff;
   // root chain
   logic sv_ff [SqN];
   logic [RW-1:0] srad_ff [SqN];
   logic [27:0] srem_ff [SqN], sroot_ff [SqN];
   logic [VarWidth-1:0] su_ff [SqN];
   logic signed [DataWidth-1:0] sm_ff [SqN];
   // magnitude stage
   logic v6_ff;
   logic [MagW-1:0] mag6_ff;
   logic [DenW-1:0] den6_ff;
   logic neg6_ff;
   logic [VarWidth-1:0] u6_ff;
   logic signed [DataWidth-1:0] m6_ff;
   // divider chain
   logic dv_ff [DivS];
   logic [MagW-1:0] dnum_ff [DivS], dquo_ff [DivS];
   logic [DenW:0] drem_ff [DivS];
   logic [DenW-1:0] dden_ff [DivS];
   logic dneg_ff [DivS];
   logic [VarWidth-1:0] du_ff [DivS];
   logic signed [DataWidth-1:0] dm_ff [DivS];
   // output
   logic vo_ff;
   rsp_type out_ff;

   logic signed [58:0] msum;
   logic signed [DataWidth-1:0] m_in;
   logic signed [DataWidth:0] dif;
   logic [DataWidth-1:0] ud;
   logic [64:0] usum;
   logic [MagW-1:0] absm;
   logic [RW-1:0] srad_in [SqN];
   logic [27:0] srem_in [SqN], sroot_in [SqN];
   logic [DenW-1:0] den_in;
   logic [MagW-1:0] dnum_in [DivS], dquo_in [DivS];
   logic [DenW:0] drem_in [DivS];
   logic [MagW-1:0] q_fin;
   logic signed [DataWidth-1:0] upd;

   always_comb begin
      msum = 59'(pm_a_ff) + 59'(pm_b_ff) + 59'sd8388608;
      m_in = DataWidth'(msum >>> BetaFrac);
      if ((msum >>> BetaFrac) > 59'sd2147483647) m_in = 32'sh7fffffff;
      else if ((msum >>> BetaFrac) < -59'sd2147483648) m_in = 32'sh80000000;
      dif = 33'(g2_ff) - 33'(m2_ff);
      ud  = dif[DataWidth] ? DataWidth'(-dif) : DataWidth'(dif);
      usum = 65'(t1_ff) + 65'(t2_ff) + 65'(cfg.eps);
      absm = sm_ff[SqN-1][DataWidth-1] ? MagW'(-33'(sm_ff[SqN-1]))
                                       : MagW'(sm_ff[SqN-1]);
      den_in = DenW'(sroot_ff[SqN-1]) + DenW'(cfg.eps);
   end

   // root step wiring
   adab_sqrt_stage u_sq0 (
      .rad_i({1'b0, u5_ff, {FracBits{1'b0}}}), .rem_i(28'd0), .root_i(28'd0),
      .rad_o(srad_in[0]), .rem_o(srem_in[0]), .root_o(sroot_in[0])
   );
   for (genvar k = 1; k < SqN; k++) begin : g_sq
      adab_sqrt_stage u_sq (
         .rad_i(srad_ff[k-1]), .rem_i(srem_ff[k-1]), .root_i(sroot_ff[k-1]),
         .rad_o(srad_in[k]), .rem_o(srem_in[k]), .root_o(sroot_in[k])
      );
   end

   // restoring divider, DivPer bits per stage
   always_comb begin
      logic [MagW-1:0] n, qq;
      logic [DenW:0] r;
      logic [DenW+1:0] t;
      logic [DenW-1:0] dd;
      for (int s = 0; s < DivS; s++) begin
         n  = (s == 0) ? mag6_ff : dnum_ff[s-1];
         qq = (s == 0) ? '0 : dquo_ff[s-1];
         r  = (s == 0) ? '0 : drem_ff[s-1];
         dd = (s == 0) ? den6_ff : dden_ff[s-1];
         for (int b = 0; b < DivPer; b++) begin
            t = {r, n[MagW-1]};
            n = n << 1;
            if (t >= (DenW+2)'(dd)) begin
               r = (DenW+1)'(t - (DenW+2)'(dd));
               qq = {qq[MagW-2:0], 1'b1};
            end else begin
               r = (DenW+1)'(t);
               qq = {qq[MagW-2:0], 1'b0};
            end
         end
         dnum_in[s] = n;
         dquo_in[s] = qq;
         drem_in[s] = r;
      end
   end

   always_comb begin
      q_fin = dquo_ff[DivS-1];
      if (dneg_ff[DivS-1]) begin
         if (q_fin > MagW'(33'h80000000)) upd = 32'sh80000000;
         else upd = DataWidth'(-q_fin);
      end else begin
         if (q_fin > MagW'(PosMax)) upd = 32'sh7fffffff;
         else upd = DataWidth'(q_fin);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; vo_ff <= 1'b0;
         for (int k = 0; k < SqN; k++) sv_ff[k] <= 1'b0;
         for (int s = 0; s < DivS; s++) dv_ff[s] <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; sv_ff[0] <= v5_ff;
         for (int k = 1; k < SqN; k++) sv_ff[k] <= sv_ff[k-1];
         v6_ff <= sv_ff[SqN-1];
         dv_ff[0] <= v6_ff;
         for (int s = 1; s < DivS; s++) dv_ff[s] <= dv_ff[s-1];
         vo_ff <= dv_ff[DivS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pm_a_ff <= $signed({1'b0, cfg.beta_mean}) * 58'(in_data.prev_mean);
         pm_b_ff <= $signed({1'b0, 25'(BetaOne - 25'(cfg.beta_mean))})
                    * 58'(in_data.gradient);
         g1_ff <= in_data.gradient; u01_ff <= in_data.prev_var;
         m2_ff <= m_in; g2_ff <= g1_ff; u02_ff <= u01_ff;
         sq3_ff <= 66'(urnd(64'(ud) * 64'(ud)));
         m3_ff <= m2_ff; u03_ff <= u02_ff;
         t2_ff <= urnd(64'(sq3_ff[39:0]) * 64'(BetaOne - 25'(cfg.beta_var)));
         t1_ff <= urnd(64'(cfg.beta_var) * 64'(u03_ff));
         m4_ff <= m3_ff;
         u5_ff <= (usum > 65'(PosMax)) ? PosMax : VarWidth'(usum);
         m5_ff <= m4_ff;
         srad_ff[0] <= srad_in[0]; srem_ff[0] <= srem_in[0];
         sroot_ff[0] <= sroot_in[0]; su_ff[0] <= u5_ff; sm_ff[0] <= m5_ff;
         for (int k = 1; k < SqN; k++) begin
            srad_ff[k] <= srad_in[k]; srem_ff[k] <= srem_in[k];
            sroot_ff[k] <= sroot_in[k]; su_ff[k] <= su_ff[k-1];
            sm_ff[k] <= sm_ff[k-1];
         end
         m6_ff <= sm_ff[SqN-1]; u6_ff <= su_ff[SqN-1];
         den6_ff <= den_in;
         // |m| * s gets its own register ahead of the divider
         mag6_ff <= 63'(absm[31:0]) * 63'(cfg.step_factor);
         neg6_ff <= sm_ff[SqN-1][DataWidth-1];
         dden_ff[0] <= den6_ff; dneg_ff[0] <= neg6_ff;
         du_ff[0] <= u6_ff; dm_ff[0] <= m6_ff;
         for (int s = 0; s < DivS; s++) begin
            dnum_ff[s] <= dnum_in[s]; dquo_ff[s] <= dquo_in[s];
            drem_ff[s] <= drem_in[s];
         end
         for (int s = 1; s < DivS; s++) begin
            dden_ff[s] <= dden_ff[s-1]; dneg_ff[s] <= dneg_ff[s-1];
            du_ff[s] <= du_ff[s-1]; dm_ff[s] <= dm_ff[s-1];
         end
         out_ff.update_value <= upd;
         out_ff.new_mean     <= dm_ff[DivS-1];
         out_ff.new_var      <= du_ff[DivS-1];
      end
   end

   assign out_valid = vo_ff;
   assign out_data  = out_ff;
endmodule
